// ===== src/stt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table package
// Shared constants, beat layouts, operation codes and controller types.
// ----------------------------------------------------------------------------
package stt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  localparam int OP_W      = 2;
  localparam int SLOT_W    = 4;
  localparam int TMO_W     = 24;
  localparam int HND_W     = 16;
  localparam int TOK_W     = 32;
  localparam int TICK_W    = 64;
  localparam int PER_W     = 10;

  localparam logic [PER_W-1:0] PERIOD_RESET = PER_W'(10);

  // Input beat layout, lowest bit first.
  localparam int S_OP_LSB   = 0;
  localparam int S_SLOT_LSB = S_OP_LSB + OP_W;
  localparam int S_TMO_LSB  = S_SLOT_LSB + SLOT_W;
  localparam int S_HND_LSB  = S_TMO_LSB + TMO_W;
  localparam int S_TOK_LSB  = S_HND_LSB + HND_W;
  localparam int S_USED_W   = S_TOK_LSB + TOK_W;
  localparam int S_DATA_W   = ((S_USED_W + 7) / 8) * 8;

  // Output beat layout, lowest bit first.
  localparam int M_SLOT_LSB = 0;
  localparam int M_HND_LSB  = M_SLOT_LSB + SLOT_W;
  localparam int M_TOK_LSB  = M_HND_LSB + HND_W;
  localparam int M_TICK_LSB = M_TOK_LSB + TOK_W;
  localparam int M_USED_W   = M_TICK_LSB + TICK_W;
  localparam int M_DATA_W   = ((M_USED_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 2'd0,
    OP_ARM    = 2'd1,
    OP_DISARM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic div_start;
    logic tick_start;
    logic disarm;
    logic arm_write;
    logic scan_step;
  } cmd_t;

  typedef struct packed {
    op_t  in_op;
    logic div_done;
    logic scan_stall;
    logic scan_end;
  } status_t;

endpackage

// ===== src/stt_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timeout divider
// Restoring divider that turns a timeout in milliseconds into ticks, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module stt_div import stt_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [TMO_W-1:0] dividend,
  input  logic [PER_W-1:0] divisor,
  output logic             done,
  output logic [TMO_W-1:0] quotient
);

  localparam int CNT_W = $clog2(TMO_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TMO_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [TMO_W-1:0] q;
  logic [PER_W-1:0] r;
  logic [PER_W-1:0] d;

  logic [PER_W:0]   shifted;
  logic [PER_W:0]   diff;
  logic             ge;
  logic [PER_W-1:0] r_next;

  always_comb begin
    shifted = {r, q[TMO_W-1]};
    diff    = shifted - {1'b0, d};
    ge      = (shifted >= {1'b0, d});
    r_next  = ge ? diff[PER_W-1:0] : shifted[PER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
      d <= divisor;
    end else if (busy) begin
      q <= {q[TMO_W-2:0], ge};
      r <= r_next;
    end
  end

  assign quotient = q;

endmodule

// ===== src/stt_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table datapath
// Slot storage, tick counter, period register, divider and output register.
// ----------------------------------------------------------------------------
module stt_datapath import stt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  output status_t             status,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                cfg_we,
  input  logic [PER_W-1:0]    cfg_wdata,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  output logic                m_tlast
);

  logic [SLOT_W-1:0] in_slot;
  logic [TMO_W-1:0]  in_tmo;
  logic [HND_W-1:0]  in_hnd;
  logic [TOK_W-1:0]  in_tok;
  logic              in_slot_ok;

  logic [PER_W-1:0]  period;
  logic [PER_W-1:0]  divisor;
  logic              div_done;
  logic [TMO_W-1:0]  quotient;

  logic [IDX_W-1:0]  arm_slot;
  logic              arm_ok;
  logic [HND_W-1:0]  arm_hnd;
  logic [TOK_W-1:0]  arm_tok;

  logic [NUM_SLOTS-1:0] armed;
  logic [TMO_W-1:0]     rem      [NUM_SLOTS];
  logic [HND_W-1:0]     slot_hnd [NUM_SLOTS];
  logic [TOK_W-1:0]     slot_tok [NUM_SLOTS];
  logic [TICK_W-1:0]    tick_total;

  logic [IDX_W-1:0]     idx;
  logic [NUM_SLOTS-1:0] mask;
  logic [NUM_SLOTS-1:0] mask_zero;
  logic [NUM_SLOTS-1:0] idx_bit;
  logic                 hit;
  logic                 out_free;
  logic                 load_out;

  logic                 out_valid;
  logic [SLOT_W-1:0]    out_slot;
  logic [HND_W-1:0]     out_hnd;
  logic [TOK_W-1:0]     out_tok;
  logic [TICK_W-1:0]    out_tick;
  logic                 out_last;

  assign in_slot    = s_tdata[S_SLOT_LSB +: SLOT_W];
  assign in_tmo     = s_tdata[S_TMO_LSB +: TMO_W];
  assign in_hnd     = s_tdata[S_HND_LSB +: HND_W];
  assign in_tok     = s_tdata[S_TOK_LSB +: TOK_W];
  assign in_slot_ok = (int'(in_slot) < NUM_SLOTS);

  always_ff @(posedge clk) begin
    if (rst) begin
      period <= PERIOD_RESET;
    end else if (cfg_we) begin
      period <= cfg_wdata;
    end
  end

  // A zero period counts as one millisecond per tick.
  assign divisor = (period == '0) ? PER_W'(1) : period;

  stt_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (in_tmo),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      arm_slot <= in_slot[IDX_W-1:0];
      arm_ok   <= in_slot_ok;
      arm_hnd  <= in_hnd;
      arm_tok  <= in_tok;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      mask_zero[i] = armed[i] && (rem[i] == '0);
    end
    idx_bit      = '0;
    idx_bit[idx] = 1'b1;
    hit          = armed[idx] && (rem[idx] == '0);
    out_free     = !out_valid || m_tready;
    load_out     = cmd.scan_step && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= '0;
      tick_total <= '0;
      idx        <= '0;
      mask       <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.disarm && in_slot_ok) begin
        armed[in_slot[IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.arm_write && arm_ok) begin
        armed[arm_slot] <= 1'b1;
      end
      if (cmd.tick_start) begin
        tick_total <= tick_total + 1'b1;
        idx        <= '0;
        mask       <= mask_zero;
      end
      if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        if (hit) begin
          armed[idx] <= 1'b0;
          mask[idx]  <= 1'b0;
        end
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.arm_write && arm_ok) begin
      rem[arm_slot]      <= quotient;
      slot_hnd[arm_slot] <= arm_hnd;
      slot_tok[arm_slot] <= arm_tok;
    end else if (cmd.scan_step && armed[idx] && !hit) begin
      rem[idx] <= rem[idx] - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_slot <= SLOT_W'(idx);
      out_hnd  <= slot_hnd[idx];
      out_tok  <= slot_tok[idx];
      out_tick <= tick_total;
      out_last <= ((mask & ~idx_bit) == '0);
    end
  end

  assign status.in_op      = op_t'(s_tdata[S_OP_LSB +: OP_W]);
  assign status.div_done   = div_done;
  assign status.scan_stall = hit && !out_free;
  assign status.scan_end   = (idx == IDX_W'(NUM_SLOTS - 1));

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(M_DATA_W - M_USED_W){1'b0}}, out_tick, out_tok, out_hnd, out_slot};

endmodule

// ===== src/stt_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer table controller
// Sequences arm, disarm and tick beats over the datapath.
// ----------------------------------------------------------------------------
module stt_ctrl import stt_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          case (status.in_op)
            OP_TICK: state_next = ST_SCAN;
            OP_ARM:  state_next = ST_DIVIDE;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_DIVIDE: begin
        if (status.div_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (!status.scan_stall && status.scan_end) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = 1'b0;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        s_tready       = 1'b1;
        cmd.div_start  = s_tvalid && (status.in_op == OP_ARM);
        cmd.tick_start = s_tvalid && (status.in_op == OP_TICK);
        cmd.disarm     = s_tvalid && (status.in_op == OP_DISARM);
      end
      ST_DIVIDE: begin
        cmd.arm_write = status.div_done;
      end
      ST_SCAN: begin
        cmd.scan_step = !status.scan_stall;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/software_timer_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table
// Sixteen one-shot timers with a global tick count and expiry reporting.
// ----------------------------------------------------------------------------
// An arm beat waits on the bit-serial divider that turns the timeout into
// ticks at one quotient bit per cycle. A tick beat walks the table one slot
// at a time, and the walk holds while an expiry waits on a full output
// register. The next input beat is taken only once the table is idle again.
// Each expiry leaves as one output beat in slot order, and the last beat of
// a tick carries tlast.
module software_timer_table import stt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PER_W-1:0]    cfg_wdata,    // tick_period_ms
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,      // op, slot, timeout_ms, handler_id, user_token
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,      // expired_slot, expired_handler, expired_token,
                                            // tick_now
  output logic                m_tlast
);

  cmd_t    cmd;
  status_t status;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  stt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== sim/timer_table_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table checker
// Watches the configuration port and both streams of the timer table. It
// keeps its own copy of the slots, the tick count and the tick period,
// predicts the expiry beats that each accepted input beat causes, and
// compares every output beat, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module timer_table_checker import stt_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [PER_W-1:0]    cfg_wdata,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [M_DATA_W-1:0] m_tdata,
  input  logic                m_tlast,
  output int                  errors,
  output int                  pending
);

  localparam int MAX_EXPIRIES = 16;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [HND_W-1:0]  handler;
    logic [TOK_W-1:0]  token;
    logic [TICK_W-1:0] tick;
    logic              last;
  } expiry_t;

  expiry_t            expiry_q[$];
  logic [PER_W-1:0]   period;
  logic               armed [NUM_SLOTS];
  logic signed [24:0] ticks_left [NUM_SLOTS];
  logic [HND_W-1:0]   handler_mem [NUM_SLOTS];
  logic [TOK_W-1:0]   token_mem [NUM_SLOTS];
  logic [TICK_W-1:0]  tick_count;
  int                 err_cnt = 0;

  task automatic check_field(input string name, input logic [TICK_W-1:0] want,
                             input logic [TICK_W-1:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, name, want, got);
    end
  endtask

  task automatic check_expiry();
    expiry_t want;
    if (expiry_q.size() == 0) begin
      err_cnt++;
      $display("%0t ns: unexpected expiry beat, expected none, actual 0x%0h last %0b",
               $time, m_tdata, m_tlast);
    end else begin
      want = expiry_q.pop_front();
      check_field("expired_slot", TICK_W'(want.slot), TICK_W'(m_tdata[M_SLOT_LSB +: SLOT_W]));
      check_field("expired_handler", TICK_W'(want.handler),
                  TICK_W'(m_tdata[M_HND_LSB +: HND_W]));
      check_field("expired_token", TICK_W'(want.token), TICK_W'(m_tdata[M_TOK_LSB +: TOK_W]));
      check_field("tick_now", want.tick, m_tdata[M_TICK_LSB +: TICK_W]);
      check_field("last", TICK_W'(want.last), TICK_W'(m_tlast));
    end
  endtask

  task automatic predict_expiries(input logic [S_DATA_W-1:0] beat);
    logic [OP_W-1:0]    op;
    logic [SLOT_W-1:0]  slot;
    logic [TMO_W-1:0]   tmo;
    logic [24:0]        divisor;
    logic signed [24:0] left;
    expiry_t            fired [MAX_EXPIRIES];
    int                 n;
    op   = beat[S_OP_LSB +: OP_W];
    slot = beat[S_SLOT_LSB +: SLOT_W];
    tmo  = beat[S_TMO_LSB +: TMO_W];
    n    = 0;
    if (op == OP_ARM) begin
      if (int'(slot) < NUM_SLOTS) begin
        divisor = (period == '0) ? 25'd1 : 25'(period);
        armed[slot]       = 1'b1;
        ticks_left[slot]  = $signed(25'(tmo) / divisor);
        handler_mem[slot] = beat[S_HND_LSB +: HND_W];
        token_mem[slot]   = beat[S_TOK_LSB +: TOK_W];
      end
    end else if (op == OP_DISARM) begin
      if (int'(slot) < NUM_SLOTS) armed[slot] = 1'b0;
    end else if (op == OP_TICK) begin
      tick_count = tick_count + 1'b1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (armed[i]) begin
          left = ticks_left[i];
          left = (left < 0) ? -25'sd1 : left - 25'sd1;
          ticks_left[i] = left;
          if (left < 0 && n < MAX_EXPIRIES) begin
            fired[n].slot    = SLOT_W'(i);
            fired[n].handler = handler_mem[i];
            fired[n].token   = token_mem[i];
            fired[n].tick    = tick_count;
            fired[n].last    = 1'b0;
            armed[i] = 1'b0;
            n++;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        fired[k].last = (k == n - 1);
        expiry_q.push_back(fired[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      period     = PERIOD_RESET;
      tick_count = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        armed[i]       = 1'b0;
        ticks_left[i]  = '0;
        handler_mem[i] = '0;
        token_mem[i]   = '0;
      end
      expiry_q.delete();
    end else begin
      if (m_tvalid && m_tready) check_expiry();
      if (s_tvalid && s_tready) predict_expiries(s_tdata);
      if (cfg_we) period = cfg_wdata;
    end
    errors  <= err_cnt;
    pending <= expiry_q.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Software timer table testbench
// Drives the timer table with a directed sequence, a back-pressure sequence
// that fills the block, and random arm, disarm and tick beats under several
// tick periods and idling patterns. A separate checker predicts and compares
// the expiry beats; this module makes the stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import stt_pkg::*;

  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 400;
  localparam int RANDOM_ITEMS   = 92;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_we = 1'b0;
  logic [PER_W-1:0]    cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  int   errors;
  int   pending;
  int   tx_idle_pct = 0;
  int   rx_stall_pct = 0;
  int   cur_period = int'(PERIOD_RESET);
  logic hold_go = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   quiet_cycles = 0;

  software_timer_table uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  timer_table_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [S_DATA_W-1:0] pack_beat(input logic [OP_W-1:0] op,
                                                    input logic [SLOT_W-1:0] slot,
                                                    input logic [TMO_W-1:0] tmo,
                                                    input logic [HND_W-1:0] hnd,
                                                    input logic [TOK_W-1:0] tok);
    logic [S_DATA_W-1:0] beat;
    beat = '0;
    beat[S_OP_LSB +: OP_W]     = op;
    beat[S_SLOT_LSB +: SLOT_W] = slot;
    beat[S_TMO_LSB +: TMO_W]   = tmo;
    beat[S_HND_LSB +: HND_W]   = hnd;
    beat[S_TOK_LSB +: TOK_W]   = tok;
    return beat;
  endfunction

  task automatic send_beat(input logic [S_DATA_W-1:0] beat);
    if (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= beat;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input int value);
    cfg_we     <= 1'b1;
    cfg_wdata  <= PER_W'(value);
    cur_period = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int               count;
    int               roll;
    int               per_eff;
    logic [OP_W-1:0]  op;
    logic [TMO_W-1:0] tmo;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed beats under the reset period of 10 ms.
    send_beat(pack_beat(OP_ARM, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_ARM, 4'd15, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(pack_beat(OP_ARM, 4'd5, 24'd9, 16'h1234, 32'hDEAD_BEEF));
    send_beat(pack_beat(OP_ARM, 4'd6, 24'd10, 16'hA5A5, 32'h5A5A_5A5A));
    send_beat(pack_beat(OP_ARM, 4'd7, 24'd25, 16'h0F0F, 32'hF0F0_F0F0));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_TICK, 4'd15, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(pack_beat(OP_ARM, 4'd7, 24'd0, 16'hBEEF, 32'h0123_4567));
    send_beat(pack_beat(OP_UNUSED, 4'd7, 24'd0, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(pack_beat(OP_DISARM, 4'd15, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_DISARM, 4'd3, 24'hFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    drain();

    // A zero period acts as one; sixteen expiries in one tick under a long stall.
    cfg_write(0);
    for (int i = 0; i < NUM_SLOTS; i++)
      send_beat(pack_beat(OP_ARM, SLOT_W'(i), 24'd0, HND_W'($urandom), $urandom));
    hold_go <= ~hold_go;
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_ARM, 4'd3, 24'd1, HND_W'($urandom), $urandom));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    send_beat(pack_beat(OP_ARM, 4'd9, 24'd0, HND_W'($urandom), $urandom));
    send_beat(pack_beat(OP_TICK, 4'd0, 24'd0, 16'h0000, 32'h0000_0000));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          cfg_write(1);
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
        1: begin
          cfg_write(1000);
          tx_idle_pct  = 66;
          rx_stall_pct = 0;
        end
        2: begin
          cfg_write(1023);
          tx_idle_pct  = 0;
          rx_stall_pct = 66;
        end
        default: begin
          cfg_write($urandom_range(1000, 1));
          tx_idle_pct  = 10;
          rx_stall_pct = 10;
        end
      endcase
      per_eff = (cur_period == 0) ? 1 : cur_period;
      count = 0;
      while (count < RANDOM_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 45) op = OP_TICK;
        else if (roll < 85) op = OP_ARM;
        else if (roll < 95) op = OP_DISARM;
        else op = OP_UNUSED;
        if ($urandom_range(9) == 0) tmo = TMO_W'($urandom);
        else tmo = TMO_W'($urandom_range(4) * per_eff + $urandom_range(per_eff - 1));
        send_beat(pack_beat(op, SLOT_W'($urandom_range(15)), tmo, HND_W'($urandom),
                            $urandom));
        if (op != OP_UNUSED) count++;
      end
      drain();
    end

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
